>>> rtl/core/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types, widths and codes of the fixed slot allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int MAX_SLOTS_DEF = 1024;

  localparam int CNT_W      = 11;
  localparam int SLOT_W     = 10;
  localparam int ID_W       = 16;
  localparam int OW_W       = 13;
  localparam int OFS_W      = 25;
  localparam int STATUS_W   = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int WORD_SHIFT = 3;  // eight bytes per word

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_NOT_ENABLED   = 3'd1,
    ST_NO_SPACE      = 3'd2,
    ST_POOL_MISMATCH = 3'd3,
    ST_NOT_ALLOCATED = 3'd4,
    ST_STACK_FULL    = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 2'd0,
    REG_POOL_ID    = 2'd1,
    REG_SLOT_LIMIT = 2'd2,
    REG_OBJ_WORDS  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic             enable;
    logic [ID_W-1:0]  pool_id;
    logic [CNT_W-1:0] slot_limit;
    logic [OW_W-1:0]  obj_words;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   block_id;
    logic [SLOT_W-1:0] slot;
    logic [OFS_W-1:0]  byte_offset;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  in_use;
    logic              full_res;
  } result_t;

endpackage

>>> rtl/core/fsa_stack_mem.sv
// ----------------------------------------------------------------------------
// fsa_stack_mem
// Free stack storage: one write port, one registered read port, with
// write-to-read forwarding for the entry that becomes the new top.
// ----------------------------------------------------------------------------
module fsa_stack_mem #(
  parameter int Depth = fsa_pkg::MAX_SLOTS_DEF,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [AddrW-1:0]          rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [fsa_pkg::SLOT_W-1:0] wr_data_i,
  output logic [fsa_pkg::SLOT_W-1:0] rd_data_o
);
  import fsa_pkg::*;

  logic [SLOT_W-1:0] mem [Depth];
  logic [SLOT_W-1:0] rd_q;
  logic [SLOT_W-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q       <= mem[rd_addr_i];
    fwd_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> rtl/core/fsa_ctrl.sv
// ----------------------------------------------------------------------------
// fsa_ctrl
// Allocation control: bump pointer, stack depth, request decode and
// result computation.
// ----------------------------------------------------------------------------
module fsa_ctrl #(
  parameter int MAX_SLOTS = fsa_pkg::MAX_SLOTS_DEF,
  parameter int AddrW     = $clog2(MAX_SLOTS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fsa_pkg::cfg_t              cfg_i,
  input  logic                       fire_i,
  input  logic                       op_i,
  input  logic [fsa_pkg::ID_W-1:0]   block_id_i,
  input  logic [fsa_pkg::SLOT_W-1:0] slot_i,
  input  logic [fsa_pkg::SLOT_W-1:0] top_data_i,
  output logic [AddrW-1:0]           rd_addr_o,
  output logic                       wr_en_o,
  output logic [AddrW-1:0]           wr_addr_o,
  output logic [fsa_pkg::SLOT_W-1:0] wr_data_o,
  output fsa_pkg::result_t           res_o
);
  import fsa_pkg::*;

  localparam int ProdW = SLOT_W + OW_W;

  logic [CNT_W-1:0]  bump_q, bump_d, bump_nxt;
  logic [CNT_W-1:0]  depth_q, depth_d, depth_nxt;
  logic [CNT_W-1:0]  lim;
  logic              push;
  logic              zero_ofs;
  status_e           status;
  logic [SLOT_W-1:0] sel_slot;
  logic [ID_W-1:0]   blk;
  logic [ProdW-1:0]  prod;
  logic [CNT_W-1:0]  room;
  logic [CNT_W:0]    fc_sum;

  assign lim = (32'(cfg_i.slot_limit) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : cfg_i.slot_limit;

  always_comb begin
    bump_nxt  = bump_q;
    depth_nxt = depth_q;
    push      = 1'b0;
    zero_ofs  = 1'b0;
    sel_slot  = '0;
    blk       = '0;
    status    = ST_OK;
    if (op_i == OP_ALLOC) begin
      if (depth_q != '0) begin
        depth_nxt = depth_q - CNT_W'(1);
        sel_slot  = top_data_i;
        blk       = cfg_i.pool_id;
      end else if (bump_q < lim) begin
        sel_slot  = bump_q[SLOT_W-1:0];
        bump_nxt  = bump_q + CNT_W'(1);
        blk       = cfg_i.pool_id;
      end else begin
        status   = ST_NO_SPACE;
        zero_ofs = 1'b1;
      end
    end else begin
      sel_slot = slot_i;
      priority if (block_id_i != cfg_i.pool_id) begin
        status = ST_POOL_MISMATCH;
      end else if ({1'b0, slot_i} >= bump_q) begin
        status = ST_NOT_ALLOCATED;
      end else if (depth_q >= lim) begin
        status = ST_STACK_FULL;
      end else begin
        push      = 1'b1;
        depth_nxt = depth_q + CNT_W'(1);
      end
    end
  end

  assign bump_d  = (fire_i && cfg_i.enable) ? bump_nxt : bump_q;
  assign depth_d = (fire_i && cfg_i.enable) ? depth_nxt : depth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bump_q  <= '0;
      depth_q <= '0;
    end else begin
      bump_q  <= bump_d;
      depth_q <= depth_d;
    end
  end

  // read ahead the entry that is top of stack after this cycle
  assign rd_addr_o = AddrW'(depth_d - CNT_W'(1));
  assign wr_en_o   = fire_i && cfg_i.enable && push;
  assign wr_addr_o = AddrW'(depth_q);
  assign wr_data_o = slot_i;

  assign prod   = ProdW'(sel_slot) * ProdW'(cfg_i.obj_words);
  assign room   = (lim > bump_nxt) ? (lim - bump_nxt) : '0;
  assign fc_sum = {1'b0, room} + {1'b0, depth_nxt};

  always_comb begin
    if (!cfg_i.enable) begin
      res_o             = '0;
      res_o.status      = ST_NOT_ENABLED;
      res_o.full_res    = 1'b1;
    end else begin
      res_o.status      = status;
      res_o.block_id    = blk;
      res_o.slot        = sel_slot;
      res_o.byte_offset = zero_ofs ? '0 : OFS_W'({prod, {WORD_SHIFT{1'b0}}});
      res_o.free_count  = fc_sum[CNT_W] ? '1 : fc_sum[CNT_W-1:0];
      res_o.in_use      = (bump_nxt > depth_nxt) ? (bump_nxt - depth_nxt) : '0;
      res_o.full_res    = (bump_nxt >= lim) && (depth_nxt == '0);
    end
  end

endmodule

>>> rtl/core/fixed_slot_allocator.sv
// ----------------------------------------------------------------------------
// fixed_slot_allocator: free-list slot allocator with bump pointer
// Registered result; one request per cycle while the output is not stalled.
// The rate is set by the free stack's single read port, read one entry ahead.
// Reset clears counters and valid flag; the stack and res_q are not reset.
// ----------------------------------------------------------------------------
module fixed_slot_allocator #(
  parameter int MAX_SLOTS = fsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fsa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [fsa_pkg::ID_W-1:0]       block_id_i,
  input  logic [fsa_pkg::SLOT_W-1:0]     slot_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fsa_pkg::STATUS_W-1:0]   status_o,
  output logic [fsa_pkg::ID_W-1:0]       out_block_id_o,
  output logic [fsa_pkg::SLOT_W-1:0]     out_slot_o,
  output logic [fsa_pkg::OFS_W-1:0]      byte_offset_o,
  output logic [fsa_pkg::CNT_W-1:0]      free_count_o,
  output logic [fsa_pkg::CNT_W-1:0]      in_use_o,
  output logic                           full_res_o
);
  import fsa_pkg::*;

  localparam int AddrW = $clog2(MAX_SLOTS);

  cfg_t              cfg_q;
  result_t           res, res_q;
  logic              out_valid_q;
  logic              fire;
  logic [AddrW-1:0]  rd_addr;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [SLOT_W-1:0] wr_data;
  logic [SLOT_W-1:0] top_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b0;
      cfg_q.pool_id    <= ID_W'(1);
      cfg_q.slot_limit <= CNT_W'(1024);
      cfg_q.obj_words  <= OW_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENABLE:     cfg_q.enable     <= cfg_wdata_i[0];
        REG_POOL_ID:    cfg_q.pool_id    <= cfg_wdata_i[ID_W-1:0];
        REG_SLOT_LIMIT: cfg_q.slot_limit <= cfg_wdata_i[CNT_W-1:0];
        REG_OBJ_WORDS:  cfg_q.obj_words  <= cfg_wdata_i[OW_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  fsa_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .fire_i     (fire),
    .op_i       (op_i),
    .block_id_i (block_id_i),
    .slot_i     (slot_i),
    .top_data_i (top_data),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .res_o      (res)
  );

  fsa_stack_mem #(
    .Depth (MAX_SLOTS),
    .AddrW (AddrW)
  ) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (top_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign out_block_id_o = res_q.block_id;
  assign out_slot_o     = res_q.slot;
  assign byte_offset_o  = res_q.byte_offset;
  assign free_count_o   = res_q.free_count;
  assign in_use_o       = res_q.in_use;
  assign full_res_o     = res_q.full_res;

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the fixed slot allocator
// Sends allocate and free requests through the valid/ready input channel,
// tracks the pool state alongside the block (bump pointer, free stack,
// occupancy) and checks every result transfer field by field, in order.
// Covers directed corner cases, then random traffic over several pool setups.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsa_pkg::*;

  localparam int MAX_SLOTS   = MAX_SLOTS_DEF;
  localparam int COUNT_MAX   = (1 << CNT_W) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 22;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  op_i;
  logic [ID_W-1:0]       block_id_i;
  logic [SLOT_W-1:0]     slot_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [STATUS_W-1:0]   status_o;
  logic [ID_W-1:0]       out_block_id_o;
  logic [SLOT_W-1:0]     out_slot_o;
  logic [OFS_W-1:0]      byte_offset_o;
  logic [CNT_W-1:0]      free_count_o;
  logic [CNT_W-1:0]      in_use_o;
  logic                  full_res_o;

  // pool state kept by the testbench
  logic              pool_enable;
  logic [ID_W-1:0]   pool_id;
  logic [CNT_W-1:0]  slot_limit;
  logic [OW_W-1:0]   obj_words;
  int                bump_count;
  int                stack_depth;
  logic [SLOT_W-1:0] free_stack [MAX_SLOTS];

  result_t           expected_results [$];
  logic [SLOT_W-1:0] held_slots [$];
  int                error_count;
  int                stall_cycles;
  bit                steady_flow;

  fixed_slot_allocator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .block_id_i     (block_id_i),
    .slot_i         (slot_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .out_block_id_o (out_block_id_o),
    .out_slot_o     (out_slot_o),
    .byte_offset_o  (byte_offset_o),
    .free_count_o   (free_count_o),
    .in_use_o       (in_use_o),
    .full_res_o     (full_res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t serve_request(op_e op, logic [ID_W-1:0] bid,
                                            logic [SLOT_W-1:0] slot);
    result_t           r;
    int                lim;
    int                fc;
    int                iu;
    logic [SLOT_W-1:0] s;
    logic [63:0]       prod;
    r = '0;
    if (!pool_enable) begin
      r.status   = ST_NOT_ENABLED;
      r.full_res = 1'b1;
      return r;
    end
    lim = (int'(slot_limit) > MAX_SLOTS) ? MAX_SLOTS : int'(slot_limit);
    s   = '0;
    if (op == OP_ALLOC) begin
      if (stack_depth > 0) begin
        stack_depth--;
        s          = free_stack[stack_depth];
        r.block_id = pool_id;
        r.status   = ST_OK;
      end else if (bump_count < lim) begin
        s          = bump_count[SLOT_W-1:0];
        bump_count++;
        r.block_id = pool_id;
        r.status   = ST_OK;
      end else begin
        r.status = ST_NO_SPACE;
      end
    end else begin
      s = slot;
      if (bid != pool_id) begin
        r.status = ST_POOL_MISMATCH;
      end else if (int'(slot) >= bump_count) begin
        r.status = ST_NOT_ALLOCATED;
      end else if (stack_depth >= lim) begin
        r.status = ST_STACK_FULL;
      end else begin
        free_stack[stack_depth] = slot;
        stack_depth++;
        r.status = ST_OK;
      end
    end
    r.slot = s;
    prod = (64'(s) * 64'(obj_words)) << WORD_SHIFT;
    r.byte_offset = (op == OP_ALLOC && r.status != ST_OK) ? '0 : prod[OFS_W-1:0];
    fc = ((lim > bump_count) ? lim - bump_count : 0) + stack_depth;
    if (fc > COUNT_MAX) fc = COUNT_MAX;
    iu = (bump_count > stack_depth) ? bump_count - stack_depth : 0;
    r.free_count = fc[CNT_W-1:0];
    r.in_use     = iu[CNT_W-1:0];
    r.full_res   = (bump_count >= lim && stack_depth == 0);
    return r;
  endfunction

  // entered and left just after a falling edge
  task automatic send_request(op_e op, logic [ID_W-1:0] bid, logic [SLOT_W-1:0] slot);
    result_t r;
    int      hits [$];
    if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i       = op;
    block_id_i = bid;
    slot_i     = slot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = serve_request(op, bid, slot);
    expected_results.push_back(r);
    if (r.status == ST_OK) begin
      if (op == OP_ALLOC) begin
        held_slots.push_back(r.slot);
      end else begin
        hits = held_slots.find_first_index(x) with (x == slot);
        if (hits.size() != 0) held_slots.delete(hits[0]);
      end
    end
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] data;
    case (idx)
      REG_ENABLE:     mask = 16'h0001;
      REG_POOL_ID:    mask = 16'hFFFF;
      REG_SLOT_LIMIT: mask = CFG_DATA_W'((1 << CNT_W) - 1);
      default:        mask = CFG_DATA_W'((1 << OW_W) - 1);
    endcase
    // unused upper bits carry noise
    data        = (CFG_DATA_W'(value) & mask) | (CFG_DATA_W'($urandom) & ~mask);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    @(posedge clk_i);
    case (idx)
      REG_ENABLE:     pool_enable = data[0];
      REG_POOL_ID:    pool_id     = data[ID_W-1:0];
      REG_SLOT_LIMIT: slot_limit  = data[CNT_W-1:0];
      default:        obj_words   = data[OW_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_traffic(int n_items, int alloc_pct, int noise_pct);
    int r;
    int pick;
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < noise_pct) begin
        if ($urandom_range(1))
          send_request(op_e'($urandom_range(1)), ID_W'($urandom), SLOT_W'($urandom));
        else  // stale or double free
          send_request(OP_FREE, pool_id,
                       SLOT_W'($urandom_range(bump_count > 0 ? bump_count - 1 : 0)));
      end else if (r < noise_pct + alloc_pct || held_slots.size() == 0) begin
        send_request(OP_ALLOC, ID_W'($urandom), SLOT_W'($urandom));
      end else begin
        pick = $urandom_range(held_slots.size() - 1);
        send_request(OP_FREE, pool_id, held_slots[pick]);
      end
    end
  endtask

  task automatic test_not_enabled();
    send_request(OP_ALLOC, 16'hFFFF, 10'h3FF);
    send_request(OP_FREE, 16'hFFFF, 10'h3FF);
    send_request(OP_FREE, 16'h0000, 10'h000);
  endtask

  task automatic test_exhaustion_and_stack_full();
    drain_results();
    write_reg(REG_ENABLE, 1);
    write_reg(REG_POOL_ID, 16'hFFFF);
    write_reg(REG_SLOT_LIMIT, 3);
    write_reg(REG_OBJ_WORDS, 8191);
    repeat (4) send_request(OP_ALLOC, 16'h0000, 10'h3FF);
    send_request(OP_FREE, 16'h0000, 10'd1);
    send_request(OP_FREE, 16'hFFFF, 10'h3FF);
    repeat (3) send_request(OP_FREE, 16'hFFFF, 10'd2);
    send_request(OP_FREE, 16'hFFFF, 10'd0);
    send_request(OP_ALLOC, 16'hFFFF, 10'h000);
  endtask

  task automatic test_limit_edges();
    drain_results();
    write_reg(REG_SLOT_LIMIT, 2);
    repeat (3) send_request(OP_ALLOC, 16'h0000, 10'h000);
    drain_results();
    write_reg(REG_SLOT_LIMIT, 0);
    send_request(OP_ALLOC, 16'h0000, 10'h000);
    send_request(OP_FREE, 16'hFFFF, 10'd0);
    drain_results();
    write_reg(REG_POOL_ID, 0);
    write_reg(REG_SLOT_LIMIT, 2047);
    write_reg(REG_OBJ_WORDS, 0);
    send_request(OP_ALLOC, 16'hFFFF, 10'h3FF);
    send_request(OP_FREE, 16'h0000, 10'd3);
    // more frees than slots handed out
    repeat (4) send_request(OP_FREE, 16'h0000, 10'd0);
  endtask

  task automatic test_small_pool();
    drain_results();
    write_reg(REG_POOL_ID, 16'h1234);
    write_reg(REG_SLOT_LIMIT, 32);
    write_reg(REG_OBJ_WORDS, 3);
    run_traffic(300, 50, 15);
  endtask

  task automatic test_fill_pool();
    drain_results();
    write_reg(REG_POOL_ID, $urandom);
    write_reg(REG_SLOT_LIMIT, 2047);
    write_reg(REG_OBJ_WORDS, 8191);
    steady_flow = 1'b1;
    run_traffic(500, 75, 10);
    drain_results();
    steady_flow = 1'b0;
    write_reg(REG_SLOT_LIMIT, 1024);
    write_reg(REG_OBJ_WORDS, 4096);
    run_traffic(900, 92, 4);
  endtask

  task automatic test_churn();
    drain_results();
    write_reg(REG_POOL_ID, $urandom);
    write_reg(REG_OBJ_WORDS, 0);
    run_traffic(300, 40, 15);
  endtask

  task automatic test_disabled_midway();
    drain_results();
    write_reg(REG_ENABLE, 0);
    run_traffic(40, 50, 30);
    drain_results();
    write_reg(REG_ENABLE, 1);
  endtask

  task automatic test_shrunk_limit();
    drain_results();
    write_reg(REG_SLOT_LIMIT, 8);
    write_reg(REG_OBJ_WORDS, $urandom_range(8191, 1));
    run_traffic(200, 50, 20);
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i = steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin : check_results
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", exp_r.status, status_o);
        check_field("out_block_id", exp_r.block_id, out_block_id_o);
        check_field("out_slot", exp_r.slot, out_slot_o);
        check_field("byte_offset", exp_r.byte_offset, byte_offset_o);
        check_field("free_count", exp_r.free_count, free_count_o);
        check_field("in_use", exp_r.in_use, in_use_o);
        check_field("full_res", exp_r.full_res, full_res_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_ENABLE;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    op_i         = OP_ALLOC;
    block_id_i   = '0;
    slot_i       = '0;
    out_ready_i  = 1'b0;
    steady_flow  = 1'b0;
    error_count  = 0;
    stall_cycles = 0;
    pool_enable  = 1'b0;
    pool_id      = 16'd1;
    slot_limit   = CNT_W'(MAX_SLOTS);
    obj_words    = 13'd1;
    bump_count   = 0;
    stack_depth  = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_not_enabled();
    test_exhaustion_and_stack_full();
    test_limit_edges();
    test_small_pool();
    test_fill_pool();
    test_churn();
    test_disabled_midway();
    test_shrunk_limit();
    drain_results();
    repeat (5) @(posedge clk_i);

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/fsa_pkg.sv
rtl/core/fsa_stack_mem.sv
rtl/core/fsa_ctrl.sv
rtl/core/fixed_slot_allocator.sv
verif/tb_top.sv
